/* sv/gha_pkg.sv */
package gha_pkg;

    localparam int MAX_SLOTS_DEF    = 256;
    localparam int VERSION_BITS_DEF = 8;

    localparam logic [1:0] FUNC_CREATE  = 2'd0;
    localparam logic [1:0] FUNC_DESTROY = 2'd1;
    localparam logic [1:0] FUNC_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DEAD = 2'd2;

    typedef struct packed {
        logic accept;
        logic pop_read;
        logic exec;
    } gha_cmd_t;

    typedef struct packed {
        logic create_pop;
    } gha_sts_t;

endpackage

/* sv/gha_req_if.sv */
interface gha_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] handle_index;
    logic [7:0] handle_version;

    modport source (output valid, output func, output handle_index, output handle_version,
                    input ready);
    modport sink (input valid, input func, input handle_index, input handle_version,
                  output ready);
endinterface

/* sv/gha_rsp_if.sv */
interface gha_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_index;
    logic [7:0] out_version;
    logic [1:0] status;

    modport source (output valid, output out_index, output out_version, output status,
                    input ready);
    modport sink (input valid, input out_index, input out_version, input status,
                  output ready);
endinterface

/* sv/gha_ctrl.sv */
module gha_ctrl
    import gha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  gha_sts_t sts,
    output gha_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept   = (state_reg == S_IDLE) && in_valid;
        cmd.pop_read = (state_reg == S_POP);
        // hold the finished request until the result register is free
        cmd.exec     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.accept)
                        state_reg <= sts.create_pop ? S_POP : S_EXEC;
                end
                S_POP:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (cmd.exec)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.exec)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    a_pop_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (state_reg == S_EXEC))
        else $error("stack pop not followed by execute");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC))
        else $error("result raised without execute");

endmodule

/* sv/gha_datapath.sv */
module gha_datapath
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int VERSION_BITS = VERSION_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  gha_cmd_t   cmd,
    output gha_sts_t   sts,
    input  logic [1:0] in_func,
    input  logic [7:0] in_index,
    input  logic [7:0] in_version,
    output logic [7:0] out_index,
    output logic [7:0] out_version,
    output logic [1:0] status
);

    localparam int IW  = $clog2(MAX_SLOTS);
    localparam int CW  = $clog2(MAX_SLOTS + 1);
    localparam int VB  = VERSION_BITS;
    localparam int CVW = (VB > 8) ? VB : 8;

    // slot word: live bit above the version
    logic [VB:0]   slot_mem [MAX_SLOTS];
    logic [IW-1:0] stack_mem [MAX_SLOTS];

    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] free_cnt_reg, free_cnt_next;

    logic [1:0]    req_func_reg;
    logic [7:0]    req_idx_reg;
    logic [7:0]    req_ver_reg;
    logic [IW-1:0] slot_cur_reg;
    logic          range_ok_reg;
    logic [VB:0]   slot_rd_reg;
    logic [IW-1:0] stack_rd_reg;

    logic [7:0]    out_index_reg, out_index_next;
    logic [7:0]    out_version_reg, out_version_next;
    logic [1:0]    status_reg, status_next;

    logic [IW-1:0] slot_addr;
    logic          accept_range;
    logic          eff_live;
    logic [VB-1:0] eff_ver;
    logic          is_live;
    logic          slot_we;
    logic [VB:0]   slot_wdata;
    logic          stack_we;

    assign sts.create_pop = (in_func == FUNC_CREATE) && (free_cnt_reg != '0);

    assign out_index   = out_index_reg;
    assign out_version = out_version_reg;
    assign status      = status_reg;

    always_comb
    begin
        if (cmd.pop_read)
            slot_addr = stack_rd_reg;
        else if (in_func == FUNC_CREATE)
            slot_addr = IW'(used_reg);
        else
            slot_addr = IW'(in_index);
        accept_range = (in_func != FUNC_CREATE) &&
                       ((CW + 8)'(in_index) < (CW + 8)'(used_reg));
    end

    // slots at or above the fill count read as reset: not live, version zero
    always_comb
    begin
        eff_live = range_ok_reg & slot_rd_reg[VB];
        eff_ver  = range_ok_reg ? slot_rd_reg[VB-1:0] : '0;
        is_live  = eff_live && (CVW'(req_ver_reg) == CVW'(eff_ver));

        used_next        = used_reg;
        free_cnt_next    = free_cnt_reg;
        slot_we          = 1'b0;
        slot_wdata       = {1'b1, eff_ver};
        stack_we         = 1'b0;
        out_index_next   = req_idx_reg;
        out_version_next = req_ver_reg;
        status_next      = ST_OK;

        case (req_func_reg)
            FUNC_CREATE:
            begin
                if (free_cnt_reg != '0)
                begin
                    free_cnt_next    = free_cnt_reg - 1'b1;
                    slot_we          = 1'b1;
                    out_index_next   = 8'(slot_cur_reg);
                    out_version_next = 8'(eff_ver);
                end
                else if (used_reg < CW'(MAX_SLOTS))
                begin
                    used_next        = used_reg + 1'b1;
                    slot_we          = 1'b1;
                    out_index_next   = 8'(slot_cur_reg);
                    out_version_next = 8'(eff_ver);
                end
                else
                begin
                    status_next      = ST_FULL;
                    out_index_next   = '0;
                    out_version_next = '0;
                end
            end
            FUNC_DESTROY:
            begin
                if (is_live && (free_cnt_reg < CW'(MAX_SLOTS)))
                begin
                    slot_we       = 1'b1;
                    slot_wdata    = {1'b0, VB'(eff_ver + 1'b1)};
                    stack_we      = 1'b1;
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                else
                begin
                    status_next = ST_DEAD;
                end
            end
            default:
            begin
                if (!is_live)
                    status_next = ST_DEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            free_cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            used_reg     <= used_next;
            free_cnt_reg <= free_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_func_reg <= in_func;
            req_idx_reg  <= in_index;
            req_ver_reg  <= in_version;
            slot_cur_reg <= slot_addr;
            range_ok_reg <= accept_range;
            stack_rd_reg <= stack_mem[IW'(free_cnt_reg - 1'b1)];
        end
        else if (cmd.pop_read)
        begin
            slot_cur_reg <= slot_addr;
            range_ok_reg <= 1'b1;
        end

        if (cmd.accept || cmd.pop_read)
            slot_rd_reg <= slot_mem[slot_addr];

        if (cmd.exec)
        begin
            out_index_reg   <= out_index_next;
            out_version_reg <= out_version_next;
            status_reg      <= status_next;
        end

        if (cmd.exec && slot_we)
            slot_mem[slot_cur_reg] <= slot_wdata;
        if (cmd.exec && stack_we)
            stack_mem[IW'(free_cnt_reg)] <= slot_cur_reg;
    end

    a_free_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= used_reg)
        else $error("free stack deeper than slots handed out");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_SLOTS))
        else $error("fill count beyond table");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_read |-> (free_cnt_reg != '0))
        else $error("pop from empty free stack");

endmodule

/* sv/generational_handle_allocator_core.sv */
// Flow: a taken request is registered together with its slot-table read; a create
// that reuses a freed slot then reads the slot popped off the free stack; execute
// writes the slot table and the result, and waits while the result is not yet taken.
// A new request is taken only when the last one has executed (ready in idle only).
// Reset: asynchronous, active low; clears the fill count, free-stack depth and control
// state only; slots at or above the fill count read as free with version zero, so no clearing pass.
module generational_handle_allocator_core
    import gha_pkg::*;
#(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int VERSION_BITS = VERSION_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);

    gha_cmd_t cmd;
    gha_sts_t sts;

    gha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gha_datapath #(
        .MAX_SLOTS    (MAX_SLOTS),
        .VERSION_BITS (VERSION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (req.func),
        .in_index    (req.handle_index),
        .in_version  (req.handle_version),
        .out_index   (rsp.out_index),
        .out_version (rsp.out_version),
        .status      (rsp.status)
    );

endmodule

/* tb/tb_generational_handle_allocator_core.sv */
module tb_generational_handle_allocator_core;
    import gha_pkg::*;

    localparam int NUM_SLOTS  = MAX_SLOTS_DEF;
    localparam int STALL_MAX  = 1000;
    localparam int CHURN_RUNS = 16;

    // unused selector, handled as a check
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] index;
        logic [7:0] version;
    } alloc_req_t;

    typedef struct packed {
        logic [7:0] out_index;
        logic [7:0] out_version;
        logic [1:0] status;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    gha_req_if req_if ();
    gha_rsp_if rsp_if ();

    generational_handle_allocator_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #4 clk = ~clk;

    // shadow of the slot tables, advanced on every accepted request
    bit [7:0] slot_ver  [NUM_SLOTS];
    bit       slot_live [NUM_SLOTS];
    bit [7:0] free_stk  [NUM_SLOTS];
    int       stk_depth;
    int       fill_count;

    alloc_req_t req_q [$];
    alloc_rsp_t due_q [$];
    alloc_req_t nxt_req;
    alloc_rsp_t got_rsp;
    alloc_rsp_t want_rsp;

    int  issued;
    int  taken;
    int  errors;
    int  stall;
    int  src_gap;
    int  snk_gap;
    bit  req_taken;
    bit  no_idle;

    function automatic bit handle_live(logic [7:0] idx, logic [7:0] ver);
        return (int'(idx) < fill_count) && slot_live[idx] && (slot_ver[idx] == ver);
    endfunction

    function automatic alloc_rsp_t alloc_result(alloc_req_t r);
        alloc_rsp_t res;
        logic [7:0] slot;
        res.out_index   = r.index;
        res.out_version = r.version;
        res.status      = ST_OK;
        if (r.func == FUNC_CREATE) begin
            if (stk_depth > 0) begin
                stk_depth--;
                slot = free_stk[stk_depth];
                slot_live[slot] = 1'b1;
                res.out_index   = slot;
                res.out_version = slot_ver[slot];
            end else if (fill_count < NUM_SLOTS) begin
                slot = fill_count[7:0];
                fill_count++;
                slot_live[slot] = 1'b1;
                res.out_index   = slot;
                res.out_version = slot_ver[slot];
            end else begin
                res.out_index   = '0;
                res.out_version = '0;
                res.status      = ST_FULL;
            end
        end else if (r.func == FUNC_DESTROY) begin
            if (handle_live(r.index, r.version)) begin
                slot_ver[r.index]  = slot_ver[r.index] + 8'd1;
                slot_live[r.index] = 1'b0;
                free_stk[stk_depth] = r.index;
                stk_depth++;
            end else begin
                res.status = ST_DEAD;
            end
        end else if (!handle_live(r.index, r.version)) begin
            // check, and the unused selector behaves as a check
            res.status = ST_DEAD;
        end
        return res;
    endfunction

    function automatic bit pick_live(output logic [7:0] idx, output logic [7:0] ver);
        int start;
        int k;
        int s;
        start = $urandom_range(0, NUM_SLOTS - 1);
        for (k = 0; k < NUM_SLOTS; k++) begin
            s = (start + k) % NUM_SLOTS;
            if (s < fill_count && slot_live[s]) begin
                idx = s[7:0];
                ver = slot_ver[s];
                return 1'b1;
            end
        end
        idx = '0;
        ver = '0;
        return 1'b0;
    endfunction

    task automatic push_req(logic [1:0] f, logic [7:0] idx, logic [7:0] ver);
        alloc_req_t r;
        r.func    = f;
        r.index   = idx;
        r.version = ver;
        // keep the handle picks close to the shadow state
        while (req_q.size() >= 2)
            @(negedge clk);
        req_q.insert(req_q.size(), r);
    endtask

    task automatic wait_drain();
        while (req_q.size() != 0 || issued != taken || due_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic mix_item(int create_w, int destroy_w);
        int r;
        logic [7:0] idx;
        logic [7:0] ver;
        bit ok;
        r = $urandom_range(0, 99);
        if (r < create_w) begin
            push_req(FUNC_CREATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (r < create_w + destroy_w) begin
            ok = pick_live(idx, ver);
            if (ok && $urandom_range(0, 7) != 0)
                push_req(FUNC_DESTROY, idx, ver);
            else if (ok)
                push_req(FUNC_DESTROY, idx, ver ^ (8'd1 << $urandom_range(0, 7)));
            else
                push_req(FUNC_DESTROY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end else if (r < 90) begin
            ok = pick_live(idx, ver);
            case ($urandom_range(0, 3))
                0: ver = ver ^ (8'd1 << $urandom_range(0, 7));
                1: idx = idx ^ (8'd1 << $urandom_range(0, 7));
                default: ;
            endcase
            push_req(($urandom_range(0, 5) == 0) ? FUNC_SPARE : FUNC_CHECK, idx, ver);
        end else begin
            push_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_if.valid || req_taken) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_if.valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    req_if.valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    nxt_req = req_q.pop_front();
                    issued++;
                    req_if.valid          <= 1'b1;
                    req_if.func           <= nxt_req.func;
                    req_if.handle_index   <= nxt_req.index;
                    req_if.handle_version <= nxt_req.version;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response backpressure
    always @(negedge clk) begin
        if (rst_n) begin
            if (snk_gap > 0) begin
                snk_gap--;
                rsp_if.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                snk_gap = $urandom_range(0, 16);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // monitor: check responses first, then predict the request taken at this edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_rsp.out_index   = rsp_if.out_index;
                got_rsp.out_version = rsp_if.out_version;
                got_rsp.status      = rsp_if.status;
                if (due_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected response: got index %0d version %0d status %0d",
                             $time, got_rsp.out_index, got_rsp.out_version, got_rsp.status);
                end else begin
                    want_rsp = due_q.pop_front();
                    if (got_rsp.out_index !== want_rsp.out_index ||
                        got_rsp.out_version !== want_rsp.out_version ||
                        got_rsp.status !== want_rsp.status) begin
                        errors++;
                        $display("%0t mismatch idx/ver/st: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want_rsp.out_index, want_rsp.out_version,
                                 want_rsp.status, got_rsp.out_index, got_rsp.out_version,
                                 got_rsp.status);
                    end
                end
            end
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                taken++;
                nxt_req = '{req_if.func, req_if.handle_index, req_if.handle_version};
                due_q.insert(due_q.size(), alloc_result(nxt_req));
            end
            if (req_taken || (rsp_if.valid && rsp_if.ready))
                stall = 0;
            else
                stall++;
        end
    end

    always @(posedge clk) begin
        if (stall >= STALL_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        int k;
        logic [7:0] s;
        logic [7:0] v;
        bit ok;

        rst_n                 = 1'b0;
        req_if.valid          = 1'b0;
        req_if.func           = FUNC_CREATE;
        req_if.handle_index   = '0;
        req_if.handle_version = '0;
        rsp_if.ready          = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, fresh slots, reuse order, stale and foreign handles
        push_req(FUNC_CHECK,   8'd0,   8'd0);
        push_req(FUNC_DESTROY, 8'd0,   8'd0);
        push_req(FUNC_SPARE,   8'd0,   8'd0);
        push_req(FUNC_CREATE,  8'd255, 8'd255);
        push_req(FUNC_CREATE,  8'd0,   8'd0);
        push_req(FUNC_CHECK,   8'd0,   8'd0);
        push_req(FUNC_CHECK,   8'd1,   8'd0);
        push_req(FUNC_CHECK,   8'd0,   8'd1);
        push_req(FUNC_CHECK,   8'd255, 8'd255);
        push_req(FUNC_CHECK,   8'd2,   8'd0);
        push_req(FUNC_DESTROY, 8'd0,   8'd0);
        push_req(FUNC_DESTROY, 8'd0,   8'd0);
        push_req(FUNC_CHECK,   8'd0,   8'd1);
        push_req(FUNC_CREATE,  8'd0,   8'd0);
        push_req(FUNC_CHECK,   8'd0,   8'd1);
        push_req(FUNC_DESTROY, 8'd1,   8'd0);
        push_req(FUNC_DESTROY, 8'd0,   8'd1);
        push_req(FUNC_CREATE,  8'd0,   8'd0);
        push_req(FUNC_CREATE,  8'd0,   8'd0);
        push_req(FUNC_SPARE,   8'd1,   8'd1);
        push_req(FUNC_DESTROY, 8'd1,   8'd255);
        push_req(FUNC_DESTROY, 8'd200, 8'd0);
        wait_drain();

        for (k = 0; k < 60; k++)
            mix_item(45, 30);
        wait_drain();

        // fill the table to the top, then run a few creates into it
        n = stk_depth + (NUM_SLOTS - fill_count) + 4;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                push_req(FUNC_CHECK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            push_req(FUNC_CREATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        wait_drain();
        push_req(FUNC_CHECK, 8'd255, slot_ver[255]);
        push_req(FUNC_CREATE, 8'd0, 8'd0);

        for (k = 0; k < 60; k++)
            mix_item(30, 45);
        wait_drain();

        // cycle one slot through destroy and create, no idling from here on
        no_idle = 1'b1;
        ok = pick_live(s, v);
        if (!ok) begin
            push_req(FUNC_CREATE, 8'd0, 8'd0);
            wait_drain();
            ok = pick_live(s, v);
        end
        for (k = 0; k < CHURN_RUNS; k++) begin
            push_req(FUNC_DESTROY, s, v);
            push_req(FUNC_CREATE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            v = v + 8'd1;
        end
        push_req(FUNC_CHECK, s, v);
        push_req(FUNC_CHECK, s, v - 8'd1);

        wait_drain();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
